/* hw/rtl/percent_escape_decoder_top_assert.svh */
// Assertion macros used by the percent-escape decoder result queue.
`ifndef PERCENT_ESCAPE_DECODER_TOP_ASSERT_SVH
`define PERCENT_ESCAPE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PCT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/pct_dec_pkg.sv */
package pct_dec_pkg;

    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_NINE = 8'h39;
    localparam logic [7:0] UPPER_A    = 8'h41;
    localparam logic [7:0] UPPER_Z    = 8'h5A;
    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] CASE_GAP   = 8'h20;
    localparam logic [7:0] HEX_TEN    = 8'd10;

    // Result queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        PHASE_IDLE  = 2'd0,
        PHASE_PCT   = 2'd1,
        PHASE_DIGIT = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } result_t;

    // Results produced by one accepted byte
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } decode_out_t;

    // Nibble value of a hex digit, no validity check, mod 256
    function automatic logic [7:0] hex_of(input logic [7:0] b);
        logic [7:0] low;
        low = b;
        if (b >= DIGIT_ZERO && b <= DIGIT_NINE) begin
            return b - DIGIT_ZERO;
        end
        if (b >= UPPER_A && b <= UPPER_Z) begin
            low = b + CASE_GAP;
        end
        return low - LOWER_A + HEX_TEN;
    endfunction

endpackage

/* hw/rtl/pct_dec_if.sv */
interface pct_in_if;
    import pct_dec_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface pct_out_if;
    import pct_dec_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

/* hw/rtl/percent_escape_decoder_top.sv */
// Channel   Dir  Payload             Handshake
// escaped   in   in_byte, in_last    valid/ready
// decoded   out  out_byte, out_last  valid/ready
//
// One input byte per cycle while the queue has room; a decoded byte is
// written to the result queue when its last input byte is taken. A percent
// sign followed by a last byte yields two bytes, so the 4-entry result queue
// sets the rate: input is taken whenever at least two queue slots are free.
// Reset (rst_n low, asynchronous) clears escape state and the queue.
// Output stalls back up into input only once the queue holds over two bytes.
module percent_escape_decoder_top
    import pct_dec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pct_in_if.sink     escaped,
    pct_out_if.source  decoded
);

    logic        accept;
    logic        has_room;
    logic        head_valid;
    result_t     head;
    decode_out_t results;

    assign escaped.ready = has_room;
    assign accept        = escaped.valid && has_room;

    pct_dec_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (escaped.in_byte),
        .in_last (escaped.in_last),
        .results (results)
    );

    pct_dec_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .results    (results),
        .has_room   (has_room),
        .head_valid (head_valid),
        .head       (head),
        .pop_ready  (decoded.ready)
    );

    assign decoded.valid    = head_valid;
    assign decoded.out_byte = head.data;
    assign decoded.out_last = head.last;

endmodule

/* hw/rtl/pct_dec_decode.sv */
module pct_dec_decode
    import pct_dec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output decode_out_t results
);

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic [7:0] held_hex;
    logic [7:0] escaped_val;

    // Combine held digit and current digit
    assign held_hex    = hex_of(held_reg);
    assign escaped_val = {held_hex[3:0], 4'b0000} + hex_of(in_byte);

    // Next-state and result selection
    always_comb
    begin
        phase_next            = phase_reg;
        held_next             = held_reg;
        results.count         = 2'd0;
        results.first.data    = in_byte;
        results.first.last    = in_last;
        results.second.data   = in_byte;
        results.second.last   = 1'b1;
        case (phase_reg)
            PHASE_PCT:
            begin
                if (in_last)
                begin
                    // percent with one byte after it: both pass through
                    results.count      = 2'd2;
                    results.first.data = PCT_CHAR;
                    results.first.last = 1'b0;
                    phase_next         = PHASE_IDLE;
                end
                else
                begin
                    held_next  = in_byte;
                    phase_next = PHASE_DIGIT;
                end
            end
            PHASE_DIGIT:
            begin
                results.count      = 2'd1;
                results.first.data = escaped_val;
                phase_next         = PHASE_IDLE;
            end
            default:
            begin
                if (in_byte == PCT_CHAR && !in_last)
                begin
                    phase_next = PHASE_PCT;
                end
                else
                begin
                    results.count = 2'd1;
                    phase_next    = PHASE_IDLE;
                end
            end
        endcase
    end

    // Escape state, advanced per accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_IDLE;
            held_reg  <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

/* hw/rtl/pct_dec_queue.sv */
`include "percent_escape_decoder_top_assert.svh"

module pct_dec_queue
    import pct_dec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  decode_out_t results,
    output logic        has_room,
    output logic        head_valid,
    output result_t     head,
    input  logic        pop_ready
);

    result_t             entries_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic [QCNT_W-1:0]   push_n;
    logic                pop;
    logic [QPTR_W-1:0]   wr_ptr_plus1;

    // Room for the two results one transaction can make
    assign has_room   = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];
    assign pop        = head_valid && pop_ready;
    assign push_n     = push ? QCNT_W'(results.count) : '0;
    assign wr_ptr_plus1 = wr_ptr_reg + QPTR_W'(1);

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + push_n - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage, up to two writes per cycle
    always_ff @(posedge clk)
    begin
        if (push && results.count != 2'd0)
        begin
            entries_reg[wr_ptr_reg] <= results.first;
        end
        if (push && results.count == 2'd2)
        begin
            entries_reg[wr_ptr_plus1] <= results.second;
        end
    end

    `PCT_ASSERT_IMPL(a_push_fits, clk, rst_n, push,
        count_reg <= QCNT_W'(QDEPTH - 2), "push into queue without room for two")
    `PCT_ASSERT_NEXT(a_pop_only, clk, rst_n, pop && push_n == '0,
        count_reg == $past(count_reg) - QCNT_W'(1), "occupancy not reduced by lone pop")
    `PCT_ASSERT_NEXT(a_double_push, clk, rst_n, push && results.count == 2'd2 && !pop,
        count_reg == $past(count_reg) + QCNT_W'(2), "double result not counted")

endmodule
